[src/fqr_pkg.sv]
// fqr_pkg: operation and status codes and the cell control bundle for
// the queue with remove-by-key; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fqr_pkg;

	// width of the handle ports
	localparam int HANDLE_W = 16;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;

	// operation codes carried on mode
	localparam logic [MODE_W-1:0] MODE_PUT    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GET    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic put;     // append, already gated by not full
		logic get;     // pop head, already gated by not empty
		logic remove;  // search and delete first match
	} ctrl_t;

endpackage

`default_nettype wire

[src/fqr_cell.sv]
// fqr_cell: one queue slot; holds a handle, compares it against the key,
// and shifts in its tail-side neighbor when it or an entry ahead of it leaves
// depends on fqr_pkg
`timescale 1ns / 1ps
`default_nettype none

module fqr_cell import fqr_pkg::*; #(
	parameter int HANDLE_BITS = 16
) (
	input  wire logic                   clk,
	input  wire ctrl_t                  ctrl,
	input  wire logic [HANDLE_BITS-1:0] key,
	input  wire logic                   occupied,
	input  wire logic                   prev_occupied,
	input  wire logic [HANDLE_BITS-1:0] next_data,
	input  wire logic                   seen_in,
	input  wire logic [HANDLE_BITS-1:0] hit_in,
	output logic                        seen_out,
	output logic [HANDLE_BITS-1:0]      hit_out,
	output logic [HANDLE_BITS-1:0]      data
);

	logic [HANDLE_BITS-1:0] data_q;
	logic                   match;
	logic                   shift;
	logic                   load;

	// key compare and first-match chain toward the tail
	always_comb begin
		match    = ctrl.remove && occupied && (data_q == key);
		seen_out = seen_in || match;
		hit_out  = (match && !seen_in) ? (hit_in | data_q) : hit_in;
		shift    = ctrl.get || (ctrl.remove && seen_out);
		load     = ctrl.put && !occupied && prev_occupied;
	end

	// slot storage: compact from the neighbor or take the appended key
	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= next_data;
		end else if (load) begin
			data_q <= key;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

[src/fifo_queue_with_remove.sv]
// fifo_queue_with_remove: queue of handles with put, get and remove by key,
// built as a row of fqr_cell slots with head at cell 0
// depends on fqr_pkg and fqr_cell
//
//   channel   handshake        payload
//   command   start / busy     mode, handle
//   result    done (strobe)    out_handle, status, occupancy
//
// one transaction is taken per cycle; busy never rises
// the result is registered and appears in the cycle after its command; the
// compare and compaction across the cell row are combinational
// reset clears the entry count and the done strobe; slot contents need no reset
// the receiver cannot stall, so done is a one-cycle strobe
`timescale 1ns / 1ps
`default_nettype none

module fifo_queue_with_remove import fqr_pkg::*; #(
	parameter int DEPTH       = 16,
	parameter int HANDLE_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [MODE_W-1:0]              mode,
	input  wire logic [HANDLE_W-1:0]            handle,
	output logic                                done,
	output logic [HANDLE_W-1:0]                 out_handle,
	output logic [STATUS_W-1:0]                 status,
	output logic [$clog2(DEPTH+1)-1:0]          occupancy
);

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int COPY_W = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

	logic [CNT_W-1:0]       count_q;
	logic                   done_q;
	logic [HANDLE_W-1:0]    out_handle_q;
	logic [STATUS_W-1:0]    status_q;
	logic [CNT_W-1:0]       occupancy_q;

	logic                   accept;
	logic                   full;
	logic                   empty;
	logic [HANDLE_BITS-1:0] key;
	ctrl_t                  ctrl;

	logic [DEPTH-1:0]       occ;
	logic [DEPTH:0]         seen;
	logic [HANDLE_BITS-1:0] hit   [DEPTH+1];
	logic [HANDLE_BITS-1:0] cdata [DEPTH+1];

	logic                   found;
	logic [HANDLE_BITS-1:0] res_data;
	logic [HANDLE_W-1:0]    res_handle;
	logic [STATUS_W-1:0]    res_status;
	logic [CNT_W-1:0]       next_count;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);

	// key sized to the stored handle width
	always_comb begin
		key             = '0;
		key[COPY_W-1:0] = handle[COPY_W-1:0];
	end

	// command decode broadcast to the cells
	always_comb begin
		ctrl.put    = accept && (mode == MODE_PUT) && !full;
		ctrl.get    = accept && (mode == MODE_GET) && !empty;
		ctrl.remove = accept && (mode == MODE_REMOVE);
	end

	// cell row, head at index 0
	assign seen[0]      = 1'b0;
	assign hit[0]       = '0;
	assign cdata[DEPTH] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [HANDLE_BITS-1:0] nxt;
		logic                   prev_occ;

		assign occ[i] = (count_q > CNT_W'(i));
		if (i == 0) begin : g_head
			assign prev_occ = 1'b1;
		end else begin : g_body
			assign prev_occ = occ[i-1];
		end
		assign nxt = cdata[i+1];

		fqr_cell #(
			.HANDLE_BITS(HANDLE_BITS)
		) u_cell (
			.clk          (clk),
			.ctrl         (ctrl),
			.key          (key),
			.occupied     (occ[i]),
			.prev_occupied(prev_occ),
			.next_data    (nxt),
			.seen_in      (seen[i]),
			.hit_in       (hit[i]),
			.seen_out     (seen[i+1]),
			.hit_out      (hit[i+1]),
			.data         (cdata[i])
		);
	end

	assign found = seen[DEPTH];

	// result selection and next count
	always_comb begin
		res_data   = '0;
		res_status = ST_DONE;
		next_count = count_q;
		case (mode)
			MODE_PUT: begin
				if (full) begin
					res_status = ST_FULL;
				end else begin
					next_count = count_q + CNT_W'(1);
				end
			end
			MODE_GET: begin
				if (empty) begin
					res_status = ST_MISS;
				end else begin
					res_data   = cdata[0];
					next_count = count_q - CNT_W'(1);
				end
			end
			MODE_REMOVE: begin
				if (found) begin
					res_data   = hit[DEPTH];
					next_count = count_q - CNT_W'(1);
				end else begin
					res_status = ST_MISS;
				end
			end
			default: begin
				res_status = ST_DONE;
			end
		endcase
		res_handle             = '0;
		res_handle[COPY_W-1:0] = res_data[COPY_W-1:0];
	end

	// count and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= next_count;
			end
		end
	end

	// result payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			out_handle_q <= res_handle;
			status_q     <= res_status;
			occupancy_q  <= next_count;
		end
	end

	assign done       = done_q;
	assign out_handle = out_handle_q;
	assign status     = status_q;
	assign occupancy  = occupancy_q;

	// count never exceeds the row length
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	// every accepted command yields a result in the next cycle
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("missing result strobe");

	// a rejected put reports a full queue
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (occupancy == CNT_W'(DEPTH)))
		else $error("full status with room left");

	// a miss carries no handle and leaves the count unchanged
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_MISS) |-> (out_handle == '0 && occupancy == count_q))
		else $error("miss result with handle or count change");

endmodule

`default_nettype wire
